FILE: rtl/hs2k_pkg.sv
// Shared types and constants for the two-key heapsort block.
// Holds the request and response word structs; no dependencies.

package hs2k_pkg;

   // Width of every key and payload field on the ports.
   localparam int DATA_WIDTH = 32;

   // Request word: one record of the set.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] in_bin;
      logic [DATA_WIDTH-1:0] in_element;
      logic [DATA_WIDTH-1:0] in_payload;
      logic                  in_last;
   } req_word_type;

   // Response word: one sorted record.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] out_bin;
      logic [DATA_WIDTH-1:0] out_element;
      logic [DATA_WIDTH-1:0] out_payload;
      logic                  out_last;
      logic                  overflow;
   } rsp_word_type;

endpackage

FILE: rtl/hs2k_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// No package dependencies.

module hs2k_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write, then registered reads that return the old contents on a collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/heapsort_two_key_desc.sv
// Two-key heapsort, descending output. Load: one record word per cycle.
// Sort: each sift fetches the record, then for each level moved down reads both
// children, compares and writes back, and finally settles the record.
// Emission: each response word waits on one registered RAM read.
// Reset is synchronous and clears control state only; the record RAM is not cleared.

module heapsort_two_key_desc
   import hs2k_pkg::*;
#(
   parameter int CAPACITY      = 64,
   parameter int BIN_WIDTH     = 32,
   parameter int ELEMENT_WIDTH = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   // Stored widths are bounded by the port fields.
   localparam int BW  = (BIN_WIDTH < DATA_WIDTH) ? BIN_WIDTH : DATA_WIDTH;
   localparam int EW  = (ELEMENT_WIDTH < DATA_WIDTH) ? ELEMENT_WIDTH : DATA_WIDTH;
   localparam int PW  = (PAYLOAD_WIDTH < DATA_WIDTH) ? PAYLOAD_WIDTH : DATA_WIDTH;
   localparam int RW  = BW + EW + PW;
   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int XW  = CW + 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] TWO_C = CW'(2);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD_RD,
      ST_BUILD_LD,
      ST_CHILD_RD,
      ST_CMP,
      ST_EXT_RD,
      ST_EXT_LD,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] heapn_ff, heapn_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] emit_ff, emit_in;
   logic          build_ff, build_in;
   logic [RW-1:0] cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_wa;
   logic [RW-1:0] ram_wd;
   logic [AW-1:0] ram_ra_a, ram_ra_b;
   logic [RW-1:0] ram_rd_a, ram_rd_b;

   logic [XW-1:0] lchild, rchild;
   logic          l_ok, r_ok;
   logic          take_l, take_r, move;
   logic [RW-1:0] sel_rec, best_rec;
   logic [XW-1:0] mpos;
   logic [CW-1:0] count_new;
   logic          fits;

   // Compound key compare: bin first, element on a tie.
   function automatic logic key_less(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [BW-1:0] ab, bb;
      logic [EW-1:0] ae, be;
      ab = a[RW-1 -: BW];
      bb = b[RW-1 -: BW];
      ae = a[PW+EW-1 -: EW];
      be = b[PW+EW-1 -: EW];
      return (ab < bb) || ((ab == bb) && (ae < be));
   endfunction

   hs2k_ram #(
      .WIDTH(RW),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (ram_wa),
      .wr_data  (ram_wd),
      .rd_addr_a(ram_ra_a),
      .rd_data_a(ram_rd_a),
      .rd_addr_b(ram_ra_b),
      .rd_data_b(ram_rd_b)
   );

   // Child positions of the node being sifted, and whether they are in the heap.
   assign lchild = XW'({pos_ff, 1'b1});
   assign rchild = lchild + XW'(1);
   assign l_ok   = lchild < {1'b0, heapn_ff};
   assign r_ok   = rchild < {1'b0, heapn_ff};

   // Pick the smallest of the moving record and its two children.
   assign take_l   = l_ok && key_less(ram_rd_a, cur_ff);
   assign sel_rec  = take_l ? ram_rd_a : cur_ff;
   assign take_r   = r_ok && key_less(ram_rd_b, sel_rec);
   assign best_rec = take_r ? ram_rd_b : sel_rec;
   assign move     = take_l || take_r;
   assign mpos     = take_r ? rchild : lchild;

   assign fits      = count_ff < CAP_C;
   assign count_new = fits ? (count_ff + ONE_C) : count_ff;

   // RAM read addresses. Every write is committed before any read of the
   // same entry is issued, so no forwarding path is needed.
   always_comb begin
      case (state_ff)
         ST_BUILD_RD: ram_ra_a = AW'(idx_ff - ONE_C);
         ST_CHILD_RD: ram_ra_a = AW'(lchild);
         ST_EXT_RD:   ram_ra_a = '0;
         ST_EMIT_RD:  ram_ra_a = emit_ff;
         ST_EMIT_LD:  ram_ra_a = emit_ff;
         default:     ram_ra_a = emit_ff;
      endcase
      case (state_ff)
         ST_CHILD_RD: ram_ra_b = r_ok ? AW'(rchild) : AW'(lchild);
         ST_EXT_RD:   ram_ra_b = AW'(idx_ff);
         default:     ram_ra_b = '0;
      endcase
   end

   // Sequencer: load, heap build, extraction and emission.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      heapn_in     = heapn_ff;
      pos_in       = pos_ff;
      emit_in      = emit_ff;
      build_in     = build_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_wa       = pos_ff;
      ram_wd       = cur_ff;
      req_ready    = 1'b0;

      case (state_ff)
         // Store incoming records; the last word starts the sort, or emission for under two.
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ram_we   = fits;
               ram_wa   = AW'(count_ff);
               ram_wd   = {req_data.in_bin[BW-1:0], req_data.in_element[EW-1:0],
                           req_data.in_payload[PW-1:0]};
               count_in = count_new;
               if (!fits) begin
                  ovf_in = 1'b1;
               end
               if (req_data.in_last) begin
                  n_in = count_new;
                  if (count_new < TWO_C) begin
                     emit_in  = '0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     idx_in   = count_new >> 1;
                     build_in = 1'b1;
                     state_in = ST_BUILD_RD;
                  end
               end
            end
         end

         ST_BUILD_RD: state_in = ST_BUILD_LD;

         // Start a sift from node idx-1 over the whole set.
         ST_BUILD_LD: begin
            cur_in   = ram_rd_a;
            pos_in   = AW'(idx_ff - ONE_C);
            heapn_in = n_ff;
            state_in = ST_CHILD_RD;
         end

         ST_EXT_RD: state_in = ST_EXT_LD;

         // Move the root to slot idx and sift the old slot idx record from the root.
         ST_EXT_LD: begin
            ram_we   = 1'b1;
            ram_wa   = AW'(idx_ff);
            ram_wd   = ram_rd_a;
            cur_in   = ram_rd_b;
            pos_in   = '0;
            heapn_in = idx_ff;
            state_in = ST_CHILD_RD;
         end

         // Issue child reads, or settle the record when the node is a leaf.
         ST_CHILD_RD: begin
            if (l_ok) begin
               state_in = ST_CMP;
            end else begin
               ram_we = 1'b1;
            end
         end

         // Move the smaller child up, or settle the record here.
         ST_CMP: begin
            if (move) begin
               ram_we   = 1'b1;
               ram_wd   = best_rec;
               pos_in   = AW'(mpos);
               state_in = ST_CHILD_RD;
            end else begin
               ram_we = 1'b1;
            end
         end

         ST_EMIT_RD: state_in = ST_EMIT_LD;

         // Hand one sorted record to the output register when it is free.
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_bin     = DATA_WIDTH'(ram_rd_a[RW-1 -: BW]);
               rsp_data_in.out_element = DATA_WIDTH'(ram_rd_a[PW+EW-1 -: EW]);
               rsp_data_in.out_payload = DATA_WIDTH'(ram_rd_a[PW-1:0]);
               rsp_data_in.overflow    = ovf_ff;
               rsp_data_in.out_last    = (CW'(emit_ff) + ONE_C) == n_ff;
               if ((CW'(emit_ff) + ONE_C) == n_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  emit_in  = emit_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: state_in = ST_LOAD;
      endcase

      // A sift has ended: choose the next sift or start emission.
      if ((state_ff == ST_CHILD_RD && !l_ok) || (state_ff == ST_CMP && !move)) begin
         if (build_ff) begin
            if (idx_ff > ONE_C) begin
               idx_in   = idx_ff - ONE_C;
               state_in = ST_BUILD_RD;
            end else begin
               build_in = 1'b0;
               idx_in   = n_ff - ONE_C;
               state_in = ST_EXT_RD;
            end
         end else begin
            if (idx_ff > ONE_C) begin
               idx_in   = idx_ff - ONE_C;
               state_in = ST_EXT_RD;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      heapn_ff    <= heapn_in;
      pos_ff      <= pos_in;
      emit_ff     <= emit_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("record count above capacity");

   // Writes during sorting stay inside the set.
   a_sort_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_LOAD) |-> (CW'(ram_wa) < n_ff))
      else $error("sort write outside the set");

   // A swap always moves the sifted record deeper.
   a_sift_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && move) |=> (pos_ff > $past(pos_ff)))
      else $error("sift did not move down");

   // Emission never reads past the last record.
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) |-> (CW'(emit_ff) < n_ff))
      else $error("emission index past the set");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for heapsort_two_key_desc: it predicts every sorted record run.
// Depends on hs2k_pkg for the request and response word types.

module testbench;
   import hs2k_pkg::*;

   localparam int RECORD_CAPACITY = 64;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int SMALL_SET_WORDS = 33;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // Stimulus waiting to be sent and sorted records waiting to come back.
   req_word_type pending_records[$];
   rsp_word_type expected_sorted[$];

   // Predictor copy of the record store.
   logic [31:0] held_bin     [RECORD_CAPACITY];
   logic [31:0] held_element [RECORD_CAPACITY];
   logic [31:0] held_payload [RECORD_CAPACITY];
   int          held_count = 0;
   bit          dropped_any = 1'b0;

   int total_words = 0;
   int accepted_words = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   bit req_taken = 1'b0;

   heapsort_two_key_desc #(
      .CAPACITY(RECORD_CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Compound key order: bin first, element breaks ties.
   function automatic bit key_below(int a, int b);
      return held_bin[a] < held_bin[b] ||
             (held_bin[a] == held_bin[b] && held_element[a] < held_element[b]);
   endfunction

   function automatic void swap_records(int a, int b);
      logic [31:0] t;
      t = held_bin[a];     held_bin[a] = held_bin[b];         held_bin[b] = t;
      t = held_element[a]; held_element[a] = held_element[b]; held_element[b] = t;
      t = held_payload[a]; held_payload[a] = held_payload[b]; held_payload[b] = t;
   endfunction

   // Min-heap sift-down over the first n slots, starting at slot i.
   function automatic void sift_down_from(int n, int i);
      int l;
      int r;
      int m;
      forever begin
         l = 2 * i + 1;
         r = 2 * i + 2;
         m = i;
         if (l < n && key_below(l, i)) m = l;
         if (r < n && key_below(r, m)) m = r;
         if (m == i) break;
         swap_records(i, m);
         i = m;
      end
   endfunction

   // Heapsort with a min-heap leaves the slots in descending key order.
   function automatic void heapsort_held(int n);
      if (n < 2) return;
      for (int i = n / 2; i > 0; i--) sift_down_from(n, i - 1);
      for (int i = n - 1; i > 0; i--) begin
         swap_records(i, 0);
         sift_down_from(i, 0);
      end
   endfunction

   // Stores a record if there is room; a set's last word yields the sorted run.
   task automatic predict_sorted_run(req_word_type w);
      rsp_word_type r;
      if (held_count < RECORD_CAPACITY) begin
         held_bin[held_count] = w.in_bin;
         held_element[held_count] = w.in_element;
         held_payload[held_count] = w.in_payload;
         held_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (w.in_last) begin
         heapsort_held(held_count);
         for (int k = 0; k < held_count; k++) begin
            r.out_bin = held_bin[k];
            r.out_element = held_element[k];
            r.out_payload = held_payload[k];
            r.out_last = (k == held_count - 1);
            r.overflow = dropped_any;
            expected_sorted.push_back(r);
         end
         held_count = 0;
         dropped_any = 1'b0;
      end
   endtask

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Compares one response word with the oldest expected sorted record.
   task automatic check_sorted_word(rsp_word_type got);
      rsp_word_type want;
      if (expected_sorted.size() == 0) begin
         $display("%0t: unexpected response word, expected none, actual %h", $time, got);
         error_count++;
      end else begin
         want = expected_sorted.pop_front();
         report_field("bin", want.out_bin, got.out_bin);
         report_field("element", want.out_element, got.out_element);
         report_field("payload", want.out_payload, got.out_payload);
         report_field("last", want.out_last, got.out_last);
         report_field("overflow", want.overflow, got.overflow);
      end
   endtask

   task automatic add_record(logic [31:0] b, logic [31:0] e, logic [31:0] p, logic last);
      req_word_type w;
      w.in_bin = b;
      w.in_element = e;
      w.in_payload = p;
      w.in_last = last;
      pending_records.push_back(w);
   endtask

   // Keys mix a narrow range, which forces ties, with extremes and full-width values.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0: return $urandom_range(3);
         1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_set(int size);
      for (int k = 0; k < size; k++)
         add_record(pick_key(), pick_key(), $urandom, k == size - 1);
   endtask

   // Idle rates move through three phases as the stimulus is consumed.
   function automatic int idle_phase();
      if (total_words == 0) return 0;
      return accepted_words * 3 / total_words;
   endfunction

   // Driver: presents request words and toggles the response stall.
   always @(negedge clock) begin
      int send_idle;
      int recv_stall;
      case (idle_phase())
         0: begin send_idle = 34; recv_stall = 52; end
         1: begin send_idle = 52; recv_stall = 34; end
         default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_records.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data <= pending_records.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // Monitor: predicts on accepted requests, checks accepted responses.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_sorted_run(req_data);
            accepted_words <= accepted_words + 1;
         end
         if (rsp_valid && rsp_ready) check_sorted_word(rsp_data);
      end
   end

   // Watchdog: ends the run when no word moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d records outstanding",
                  $time, expected_sorted.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int small_words;
      int size;

      // Directed sets: single records pass through unsorted.
      add_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_record(32'h0, 32'h0, 32'h0, 1'b1);
      // Two records at opposite extremes.
      add_record(32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
      add_record(32'hFFFF_FFFF, 32'h0, 32'h8765_4321, 1'b1);
      // Equal bins, so the element key decides; one full duplicate key.
      add_record(32'd5, 32'd3, 32'hA000_0001, 1'b0);
      add_record(32'd5, 32'd1, 32'hA000_0002, 1'b0);
      add_record(32'd5, 32'd4, 32'hA000_0003, 1'b0);
      add_record(32'd5, 32'd1, 32'hA000_0004, 1'b1);
      // All keys equal; only the payload order shows the sift sequence.
      for (int k = 0; k < 5; k++) add_record(32'd7, 32'd9, 32'hB000_0000 + k, k == 4);
      // Already ascending, then already descending.
      for (int k = 0; k < 4; k++) add_record(k, 32'hFFFF_FFF0 + k, 32'hC000_0000 + k, k == 3);
      for (int k = 0; k < 4; k++) add_record(3 - k, k, 32'h5555_AAAA ^ k, k == 3);

      // Random sets, mostly small; one set that fills the store and overflows
      // it, with the last word dropped, follows the set that brings the total to 15 or more.
      small_words = 0;
      while (small_words < SMALL_SET_WORDS) begin
         if ($urandom_range(99) < 75) size = $urandom_range(8, 1);
         else size = $urandom_range(24, 9);
         add_random_set(size);
         small_words += size;
         if (small_words >= 15 && small_words - size < 15)
            add_random_set(RECORD_CAPACITY + 2);
      end
      total_words = pending_records.size();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (accepted_words != total_words) @(posedge clock);
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (error_count == 0 && expected_sorted.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
